[hw/rtl/bfc_pkg.sv]
// Shared constants and types for the box/frustum classifier.
`default_nettype none
package bfc_pkg;

    localparam int PLANE_SLOTS  = 6;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int COEF_W       = 16;
    localparam int OFFSET_SHIFT = 14;
    localparam int CORNERS      = 8;
    localparam int VIS_W        = 2;

    localparam logic [VIS_W-1:0] VIS_OUTSIDE      = 2'd0;
    localparam logic [VIS_W-1:0] VIS_INTERSECTING = 2'd1;
    localparam logic [VIS_W-1:0] VIS_INSIDE       = 2'd2;

    // Running verdict handed from cell to cell along with the box.
    typedef struct packed {
        logic valid;
        logic outside;
        logic all_full;
    } bfc_flags_t;

endpackage
`default_nettype wire

[hw/rtl/bfc_if.sv]
// Valid/ready channel interfaces: box input, visibility output, register writes.
`default_nettype none
interface bfc_box_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] min_x;
    logic signed [COORD_WIDTH-1:0] min_y;
    logic signed [COORD_WIDTH-1:0] min_z;
    logic signed [COORD_WIDTH-1:0] max_x;
    logic signed [COORD_WIDTH-1:0] max_y;
    logic signed [COORD_WIDTH-1:0] max_z;

    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
    modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface bfc_vis_if;
    logic       valid;
    logic       ready;
    logic [1:0] visibility;

    modport source (output valid, visibility, input ready);
    modport sink   (input valid, visibility, output ready);
endinterface

interface bfc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/bfc_cell.sv]
// One plane cell: three register stages testing the box corners against one plane.
`default_nettype none
module bfc_cell
    import bfc_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic [CFG_DATA_W-1:0]  plane,
    input  wire bfc_flags_t             flags_in,
    input  wire logic [COORD_WIDTH-1:0] lo_in [3],
    input  wire logic [COORD_WIDTH-1:0] hi_in [3],
    output bfc_flags_t                  flags_out,
    output logic [COORD_WIDTH-1:0]      lo_out [3],
    output logic [COORD_WIDTH-1:0]      hi_out [3]
);

    localparam int PW = COORD_WIDTH + COEF_W;
    // d scaled by 2^14 needs 30 bits; three products need two guard bits
    localparam int SW = (PW + 2 > COEF_W + OFFSET_SHIFT + 2) ? PW + 2
                                                              : COEF_W + OFFSET_SHIFT + 2;

    logic signed [COEF_W-1:0] coef [4];

    // stage 1: products
    bfc_flags_t               flags1_reg;
    logic [COORD_WIDTH-1:0]   lo1_reg [3];
    logic [COORD_WIDTH-1:0]   hi1_reg [3];
    logic signed [PW-1:0]     pl_reg [3];
    logic signed [PW-1:0]     ph_reg [3];
    logic signed [SW-1:0]     d_reg;
    // stage 2: partial sums
    bfc_flags_t               flags2_reg;
    logic [COORD_WIDTH-1:0]   lo2_reg [3];
    logic [COORD_WIDTH-1:0]   hi2_reg [3];
    logic signed [SW-1:0]     xy_reg [4];
    logic signed [SW-1:0]     zd_reg [2];
    // stage 3: verdict
    bfc_flags_t               flags3_reg;
    bfc_flags_t               flags3_next;
    logic [COORD_WIDTH-1:0]   lo3_reg [3];
    logic [COORD_WIDTH-1:0]   hi3_reg [3];

    logic signed [SW-1:0]     corner_sum [CORNERS];
    logic [CORNERS-1:0]       pos;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            coef[i] = plane[COEF_W*i +: COEF_W];
        end
    end

    always_comb
    begin
        for (int k = 0; k < CORNERS; k++)
        begin
            corner_sum[k] = xy_reg[k % 4] + zd_reg[k / 4];
            pos[k]        = !corner_sum[k][SW-1] && (corner_sum[k] != '0);
        end
        flags3_next.valid    = flags2_reg.valid;
        flags3_next.outside  = flags2_reg.outside || !(|pos);
        flags3_next.all_full = flags2_reg.all_full && (&pos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags1_reg <= '0;
            flags2_reg <= '0;
            flags3_reg <= '0;
        end
        else if (en)
        begin
            flags1_reg <= flags_in;
            flags2_reg <= flags1_reg;
            flags3_reg <= flags3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pl_reg[i]  <= PW'(coef[i]) * PW'($signed(lo_in[i]));
                ph_reg[i]  <= PW'(coef[i]) * PW'($signed(hi_in[i]));
                lo1_reg[i] <= lo_in[i];
                hi1_reg[i] <= hi_in[i];
                lo2_reg[i] <= lo1_reg[i];
                hi2_reg[i] <= hi1_reg[i];
                lo3_reg[i] <= lo2_reg[i];
                hi3_reg[i] <= hi2_reg[i];
            end
            d_reg <= SW'(coef[3]) <<< OFFSET_SHIFT;
            for (int k = 0; k < 4; k++)
            begin
                xy_reg[k] <= SW'((k % 2 == 1) ? ph_reg[0] : pl_reg[0])
                           + SW'((k / 2 == 1) ? ph_reg[1] : pl_reg[1]);
            end
            zd_reg[0] <= d_reg + SW'(pl_reg[2]);
            zd_reg[1] <= d_reg + SW'(ph_reg[2]);
        end
    end

    assign flags_out = flags3_reg;
    assign lo_out    = lo3_reg;
    assign hi_out    = hi3_reg;

endmodule
`default_nettype wire

[hw/rtl/box_frustum_classify_top.sv]
// Top level of the box/frustum classifier: plane registers, cell chain, output register.
`default_nettype none
// Classifies one axis-aligned box per cycle against PLANE_COUNT frustum planes.
// Each plane has its own cell in a chain; a cell is three register stages
// (products, partial sums, eight corner sums with sign test); a box passes
// through every cell in turn, its verdict then held in the output register.
// Unless the output register is full and the sink not ready, one box is
// accepted every cycle. The whole chain moves on one enable, so it stalls only
// while a result sits in the output register and the sink is not ready.
// Planes are written through the register port (index 0..5, a/b/c/d as signed
// 16-bit fields low to high); writes to other indexes are dropped. Write the
// planes only while no box is in flight. After reset all planes are zero and
// every box reads as outside.
module box_frustum_classify_top
    import bfc_pkg::*;
#(
    parameter int PLANE_COUNT = 6,
    parameter int COORD_WIDTH = 16
)(
    input  wire logic clk,
    input  wire logic rst_n,
    bfc_box_if.sink   box_in,
    bfc_vis_if.source vis_out,
    bfc_cfg_if.sink   cfg
);

    logic [CFG_DATA_W-1:0]  plane_reg [PLANE_SLOTS];

    // chain taps; tap 0 is the input, tap PLANE_COUNT the end of the chain
    bfc_flags_t             flags_tap [PLANE_COUNT+1];
    logic [COORD_WIDTH-1:0] lo_tap    [PLANE_COUNT+1][3];
    logic [COORD_WIDTH-1:0] hi_tap    [PLANE_COUNT+1][3];

    logic                   advance;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [VIS_W-1:0]       vis_reg;
    logic [VIS_W-1:0]       vis_next;

    // register port: always ready, out-of-range indexes ignored
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PLANE_SLOTS; p++)
            begin
                plane_reg[p] <= '0;
            end
        end
        else if (cfg.valid && (int'(cfg.index) < PLANE_SLOTS))
        begin
            plane_reg[cfg.index] <= cfg.data;
        end
    end

    // whole chain steps when the output register is free or being drained
    assign advance      = !out_valid_reg || vis_out.ready;
    assign box_in.ready = advance;

    assign flags_tap[0].valid    = box_in.valid;
    assign flags_tap[0].outside  = 1'b0;
    assign flags_tap[0].all_full = 1'b1;
    assign lo_tap[0][0] = box_in.min_x;
    assign lo_tap[0][1] = box_in.min_y;
    assign lo_tap[0][2] = box_in.min_z;
    assign hi_tap[0][0] = box_in.max_x;
    assign hi_tap[0][1] = box_in.max_y;
    assign hi_tap[0][2] = box_in.max_z;

    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_cell
        bfc_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .plane     (plane_reg[p]),
            .flags_in  (flags_tap[p]),
            .lo_in     (lo_tap[p]),
            .hi_in     (hi_tap[p]),
            .flags_out (flags_tap[p+1]),
            .lo_out    (lo_tap[p+1]),
            .hi_out    (hi_tap[p+1])
        );
    end

    // final verdict: any empty plane wins, then all-full, else intersecting
    always_comb
    begin
        out_valid_next = out_valid_reg;
        vis_next       = vis_reg;
        if (advance)
        begin
            out_valid_next = flags_tap[PLANE_COUNT].valid;
            if (flags_tap[PLANE_COUNT].outside)
            begin
                vis_next = VIS_OUTSIDE;
            end
            else if (flags_tap[PLANE_COUNT].all_full)
            begin
                vis_next = VIS_INSIDE;
            end
            else
            begin
                vis_next = VIS_INTERSECTING;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vis_reg <= vis_next;
    end

    assign vis_out.valid      = out_valid_reg;
    assign vis_out.visibility = vis_reg;

endmodule
`default_nettype wire

[hw/rtl/bfc_checker.sv]
// Port-level checks on the classifier and their bind to the top level.
`default_nettype none
module bfc_checker
    import bfc_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [VIS_W-1:0] visibility,
    input wire logic             cfg_ready
);

    a_vis_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (visibility == VIS_OUTSIDE || visibility == VIS_INTERSECTING
                       || visibility == VIS_INSIDE))
        else $error("visibility code out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(visibility))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("register port not ready");

endmodule

bind box_frustum_classify_top bfc_checker u_bfc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (box_in.ready),
    .out_valid  (vis_out.valid),
    .out_ready  (vis_out.ready),
    .visibility (vis_out.visibility),
    .cfg_ready  (cfg.ready)
);
`default_nettype wire
